/* rtl/ilpwm_pkg.sv */
package ilpwm_pkg;

  // Field widths fixed by the bus and PWM format.
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ReplyW = 2;
  localparam int unsigned LedW   = 3;

  // Default number of PWM channels.
  localparam int unsigned DefaultChannels = 3;

  // Event codes.
  localparam logic [CmdW-1:0] CmdTick   = 3'd0;
  localparam logic [CmdW-1:0] CmdAddr   = 3'd1;
  localparam logic [CmdW-1:0] CmdStop   = 3'd2;
  localparam logic [CmdW-1:0] CmdWrite  = 3'd3;
  localparam logic [CmdW-1:0] CmdRead   = 3'd4;
  localparam logic [CmdW-1:0] CmdBusErr = 3'd5;

  // Bus reply codes.
  localparam logic [ReplyW-1:0] ReplyNone = 2'd0;
  localparam logic [ReplyW-1:0] ReplyAck  = 2'd1;
  localparam logic [ReplyW-1:0] ReplyNak  = 2'd2;

  // A duty of all ones keeps the channel on for the whole period.
  localparam logic [ByteW-1:0] FullDuty = 8'hFF;

  // One registered request on its way into the execution stage.
  typedef struct packed {
    logic             valid;
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] data_byte;
  } item_t;

endpackage

/* rtl/ilpwm_if.sv */
// Request channel: one event per transfer.
interface ilpwm_req_if;
  logic                      valid;
  logic                      ready;
  logic [ilpwm_pkg::CmdW-1:0]  command;
  logic [ilpwm_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// Result channel: one result per request.
interface ilpwm_res_if;
  logic                        valid;
  logic                        ready;
  logic [ilpwm_pkg::ReplyW-1:0] bus_reply;
  logic [ilpwm_pkg::ByteW-1:0]  read_byte;
  logic [ilpwm_pkg::LedW-1:0]   led_outputs;

  modport source (output valid, output bus_reply, output read_byte, output led_outputs,
                  input ready);
  modport sink   (input valid, input bus_reply, input read_byte, input led_outputs,
                  output ready);
endinterface

/* rtl/ilpwm_in_reg.sv */
module ilpwm_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [ilpwm_pkg::CmdW-1:0]  command_i,
  input  logic [ilpwm_pkg::ByteW-1:0] data_byte_i,
  input  logic                      take_i,
  output ilpwm_pkg::item_t          item_o
);
  import ilpwm_pkg::*;

  logic             valid_q, valid_d;
  logic [CmdW-1:0]  command_q;
  logic [ByteW-1:0] data_q;

  // The register is free when empty or when its item moves on this cycle.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      command_q <= command_i;
      data_q    <= data_byte_i;
    end
  end

  assign item_o = '{valid: valid_q, command: command_q, data_byte: data_q};

endmodule

/* rtl/ilpwm_core.sv */
module ilpwm_core #(
  parameter int unsigned CHANNELS = ilpwm_pkg::DefaultChannels
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ilpwm_pkg::item_t            item_i,
  output logic                        take_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [ilpwm_pkg::ReplyW-1:0] bus_reply_o,
  output logic [ilpwm_pkg::ByteW-1:0]  read_byte_o,
  output logic [ilpwm_pkg::LedW-1:0]   led_outputs_o
);
  import ilpwm_pkg::*;

  localparam int unsigned IdxW = $clog2(CHANNELS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS);

  // PWM and bus state.
  logic [ByteW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] shadow_q  [CHANNELS];
  logic [ByteW-1:0] shadow_d  [CHANNELS];
  logic [ByteW-1:0] live_q    [CHANNELS];
  logic [ByteW-1:0] live_d    [CHANNELS];
  logic [ByteW-1:0] latched_q [CHANNELS];
  logic [ByteW-1:0] latched_d [CHANNELS];

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [ReplyW-1:0] reply_q, reply_d;
  logic [ByteW-1:0]  rbyte_q, rbyte_d;
  logic [LedW-1:0]   led_q, led_d;

  logic             idx_in_range;
  logic [IdxW-1:0]  idx_inc;

  // A request executes when the result register can take its result.
  assign take_o = item_i.valid && (!out_valid_q || ready_i);

  assign idx_in_range = idx_q < LastIdx;
  assign idx_inc      = idx_q + IdxW'(1);

  // Execute one event against the current state.
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    shadow_d  = shadow_q;
    live_d    = live_q;
    latched_d = latched_q;
    reply_d   = ReplyNone;
    rbyte_d   = '0;
    unique case (item_i.command)
      CmdTick: begin
        cnt_d = cnt_q + ByteW'(1);
        if (cnt_q == FullDuty) begin
          latched_d = live_q;
        end
      end
      CmdAddr: begin
        idx_d   = '0;
        reply_d = ReplyAck;
      end
      CmdStop: begin
        live_d  = shadow_q;
        reply_d = ReplyNak;
      end
      CmdWrite: begin
        reply_d = ReplyNak;
        if (idx_in_range) begin
          for (int unsigned ch = 0; ch < CHANNELS; ch++) begin
            if (idx_q == IdxW'(ch)) begin
              shadow_d[ch] = item_i.data_byte;
            end
          end
          idx_d = idx_inc;
          if (idx_inc < LastIdx) begin
            reply_d = ReplyAck;
          end
        end
      end
      CmdRead: begin
        if (idx_in_range) begin
          for (int unsigned ch = 0; ch < CHANNELS; ch++) begin
            if (idx_q == IdxW'(ch)) begin
              rbyte_d = live_q[ch];
            end
          end
          idx_d = idx_inc;
        end
      end
      CmdBusErr: begin
        reply_d = ReplyNak;
      end
      default: begin
      end
    endcase
  end

  // Channel outputs follow the updated counter and latched duties.
  for (genvar ch = 0; ch < LedW; ch++) begin : g_led
    if (ch < CHANNELS) begin : g_on
      assign led_d[ch] = (cnt_d < latched_d[ch]) || (latched_d[ch] == FullDuty);
    end else begin : g_off
      assign led_d[ch] = 1'b0;
    end
  end

  // The result register holds until taken, and is refilled by each executed request.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      shadow_q    <= '{default: '0};
      live_q      <= '{default: '0};
      latched_q   <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        cnt_q     <= cnt_d;
        idx_q     <= idx_d;
        shadow_q  <= shadow_d;
        live_q    <= live_d;
        latched_q <= latched_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      reply_q <= reply_d;
      rbyte_q <= rbyte_d;
      led_q   <= led_d;
    end
  end

  assign valid_o       = out_valid_q;
  assign bus_reply_o   = reply_q;
  assign read_byte_o   = rbyte_q;
  assign led_outputs_o = led_q;

endmodule

/* rtl/i2c_loaded_three_channel_pwm.sv */
// PWM LED driver whose duties are loaded by I2C slave events.
// The request channel carries one event each: a PWM tick, an address match,
// a stop, a master write byte, a master read or a bus error. The result channel
// returns exactly one result per request: the bus reply, the byte for a master
// read and the channel outputs after the event has been applied.
// A request passes through two registers: the accepting edge loads the input
// register, and the event is executed into the result register once that
// register can take the result. Throughput is one request per cycle while
// results are taken, set by the single execution stage; the whole event fits
// in one pass between the two registers.
// When the result receiver stalls, the result register holds its value, the
// input register still takes one more request, and then ready falls until the
// result is taken. No request is dropped or executed twice.
// Reset clears the counter, the byte index, all duty registers and both valid
// flags; the result payload, channel outputs included, is not reset.
module i2c_loaded_three_channel_pwm #(
  parameter int unsigned CHANNELS = ilpwm_pkg::DefaultChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilpwm_req_if.sink   req_i,
  ilpwm_res_if.source res_o
);
  import ilpwm_pkg::*;

  item_t item;
  logic  take;

  ilpwm_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (req_i.valid),
    .ready_o     (req_i.ready),
    .command_i   (req_i.command),
    .data_byte_i (req_i.data_byte),
    .take_i      (take),
    .item_o      (item)
  );

  ilpwm_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .take_o        (take),
    .valid_o       (res_o.valid),
    .ready_i       (res_o.ready),
    .bus_reply_o   (res_o.bus_reply),
    .read_byte_o   (res_o.read_byte),
    .led_outputs_o (res_o.led_outputs)
  );

endmodule

/* dv/ilpwm_result_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the PWM driver, keeps its own copy of the driver
// state, and compares every result with the oldest outstanding prediction.
module ilpwm_result_checker
  import ilpwm_pkg::*;
#(
  parameter int unsigned CHANNELS = DefaultChannels
) (
  input  logic clk_i,
  input  logic rst_ni,
  ilpwm_req_if req_i,
  ilpwm_res_if res_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o
);

  // One predicted result.
  typedef struct packed {
    logic [ReplyW-1:0] reply;
    logic [ByteW-1:0]  rd_byte;
    logic [LedW-1:0]   leds;
  } pwm_outcome_t;

  // Shadow of the driver state.
  logic [ByteW-1:0] pwm_count;
  int unsigned      byte_idx;
  logic [ByteW-1:0] shadow_duty  [CHANNELS];
  logic [ByteW-1:0] live_duty    [CHANNELS];
  logic [ByteW-1:0] latched_duty [CHANNELS];

  pwm_outcome_t     awaited_outcomes[$];
  int               errors = 0;
  int               checked = 0;

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 30) begin
      $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    errors++;
  endtask

  // Applies one bus or tick event to the state copy and returns the result.
  function automatic pwm_outcome_t apply_bus_event(logic [CmdW-1:0] cmd,
                                                   logic [ByteW-1:0] data);
    pwm_outcome_t o;
    o = '0;
    o.reply = ReplyNone;
    case (cmd)
      CmdTick: begin
        pwm_count = pwm_count + 1'b1;
        // The live duties take effect only when the counter wraps.
        if (pwm_count == '0) begin
          for (int ch = 0; ch < CHANNELS; ch++) latched_duty[ch] = live_duty[ch];
        end
      end
      CmdAddr: begin
        byte_idx = 0;
        o.reply  = ReplyAck;
      end
      CmdStop: begin
        for (int ch = 0; ch < CHANNELS; ch++) live_duty[ch] = shadow_duty[ch];
        o.reply = ReplyNak;
      end
      CmdWrite: begin
        if (byte_idx < CHANNELS) begin
          shadow_duty[byte_idx] = data;
          byte_idx++;
          o.reply = (byte_idx < CHANNELS) ? ReplyAck : ReplyNak;
        end else begin
          o.reply = ReplyNak;
        end
      end
      CmdRead: begin
        // Past the last channel the index stays put and zero is returned.
        if (byte_idx < CHANNELS) begin
          o.rd_byte = live_duty[byte_idx];
          byte_idx++;
        end
      end
      CmdBusErr: begin
        o.reply = ReplyNak;
      end
      default: ;
    endcase
    // Outputs reflect the state after this event; full duty is always on.
    for (int ch = 0; ch < CHANNELS && ch < LedW; ch++) begin
      if (pwm_count < latched_duty[ch] || latched_duty[ch] == FullDuty) o.leds[ch] = 1'b1;
    end
    return o;
  endfunction

  // Check accepted results first, then queue the prediction for a new request.
  always @(posedge clk_i or negedge rst_ni) begin
    pwm_outcome_t want;
    if (!rst_ni) begin
      pwm_count = '0;
      byte_idx  = 0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        shadow_duty[ch]  = '0;
        live_duty[ch]    = '0;
        latched_duty[ch] = '0;
      end
      awaited_outcomes.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("result count (result with no request outstanding)", 1, 0);
        end else begin
          want = awaited_outcomes.pop_front();
          checked++;
          if (res_i.bus_reply !== want.reply) begin
            report_mismatch("bus_reply", res_i.bus_reply, want.reply);
          end
          if (res_i.read_byte !== want.rd_byte) begin
            report_mismatch("read_byte", res_i.read_byte, want.rd_byte);
          end
          if (res_i.led_outputs !== want.leds) begin
            report_mismatch("led_outputs", res_i.led_outputs, want.leds);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        awaited_outcomes.push_back(apply_bus_event(req_i.command, req_i.data_byte));
      end
    end
    errors_o  <= errors;
    pending_o <= awaited_outcomes.size();
    checked_o <= checked;
  end

endmodule

/* dv/tb_i2c_loaded_three_channel_pwm.sv */
`timescale 1ns / 1ps

module tb_i2c_loaded_three_channel_pwm;
  import ilpwm_pkg::*;

  localparam int unsigned RandomItems = 1880;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainEvery  = 500;

  // Command codes the driver does not decode.
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  // Result receiver stall styles.
  typedef enum int unsigned {RxFree, RxLight, RxHalf, RxPulsed} rx_mode_e;

  logic        clk;
  logic        rst_n;
  int          errors;
  int          pending;
  int          checked;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned sent_total;
  int unsigned cmd_count [8];

  ilpwm_req_if req_if ();
  ilpwm_res_if res_if ();

  i2c_loaded_three_channel_pwm DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  ilpwm_result_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .res_i     (res_if),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Cycle limit of %0d reached with %0d results outstanding", CycleLimit, pending);
    $display("tb_i2c_loaded_three_channel_pwm: done, errors");
    $finish;
  end

  // The result side stalls in stretches of changing style.
  initial begin : result_receiver
    rx_mode_e    rx_mode;
    int unsigned span;
    int unsigned rx_phase;
    res_if.ready <= 1'b0;
    rx_phase = 0;
    wait (rst_n === 1'b1);
    forever begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      span    = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        rx_phase++;
        case (rx_mode)
          RxFree:   res_if.ready <= 1'b1;
          RxLight:  res_if.ready <= ($urandom_range(0, 3) != 0);
          RxHalf:   res_if.ready <= ($urandom_range(0, 1) != 0);
          default:  res_if.ready <= (rx_phase % 4 == 3);
        endcase
      end
    end
  end

  // Sends one request, idling first when the current burst is used up.
  task automatic send_event(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.data_byte <= data;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    cmd_count[cmd]++;
    sent_total++;
  endtask

  // Holds the request side until every outstanding result has been taken.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Duty values lean toward the edges of the range.
  function automatic logic [ByteW-1:0] pick_duty();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hFE;
      3:       return FullDuty;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_event(CmdTick, ByteW'($urandom_range(0, 255)));
  endtask

  // Usually an address, zero to four data bytes, then usually a stop.
  task automatic write_frame();
    int unsigned nbytes;
    if ($urandom_range(0, 9) != 0) send_event(CmdAddr, ByteW'($urandom_range(0, 255)));
    nbytes = $urandom_range(0, 4);
    repeat (nbytes) send_event(CmdWrite, pick_duty());
    case ($urandom_range(0, 9))
      0:       send_event(CmdBusErr, ByteW'($urandom_range(0, 255)));
      1:       ;
      default: send_event(CmdStop, ByteW'($urandom_range(0, 255)));
    endcase
  endtask

  // Address then one to four reads, sometimes without the address.
  task automatic read_frame();
    int unsigned nreads;
    if ($urandom_range(0, 9) != 0) send_event(CmdAddr, ByteW'($urandom_range(0, 255)));
    nreads = $urandom_range(1, 4);
    repeat (nreads) send_event(CmdRead, ByteW'($urandom_range(0, 255)));
  endtask

  // Any code with any data, spare codes included.
  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) send_event(CmdW'($urandom_range(0, 7)), ByteW'($urandom_range(0, 255)));
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned pick;
    int unsigned next_drain;
    rst_n            = 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CmdTick;
    req_if.data_byte <= '0;
    burst_left = 0;
    sent_total = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full write with an extra byte past the last channel, then stop.
    send_event(CmdAddr, 8'h00);
    send_event(CmdWrite, FullDuty);
    send_event(CmdWrite, 8'h00);
    send_event(CmdWrite, 8'h80);
    send_event(CmdWrite, 8'h5A);
    send_event(CmdStop, 8'hFF);
    // Read back all channels and one past the end.
    send_event(CmdAddr, 8'hFF);
    repeat (4) send_event(CmdRead, 8'hFF);
    // Bus error, undecoded codes, and a write with the index saturated.
    send_event(CmdBusErr, 8'hFF);
    send_event(CmdSpareLo, 8'hFF);
    send_event(CmdSpareHi, 8'h00);
    send_event(CmdWrite, 8'h33);
    send_ticks(3);
    drain_results();

    // One full period so that full, zero and half duty get latched.
    send_ticks(300);
    next_drain = sent_total + DrainEvery;
    while (sent_total < RandomItems) begin
      if (sent_total >= next_drain) begin
        drain_results();
        next_drain = sent_total + DrainEvery;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        write_frame();
      end else if (pick < 65) begin
        read_frame();
      end else if (pick < 90) begin
        send_ticks($urandom_range(1, 300));
      end else begin
        noise_burst();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d ticks (%0d counter wraps), %0d writes, %0d reads.",
             sent_total, cmd_count[CmdTick], cmd_count[CmdTick] / 256,
             cmd_count[CmdWrite], cmd_count[CmdRead]);
    $display("Also %0d address, %0d stop, %0d bus error, %0d spare; %0d results checked.",
             cmd_count[CmdAddr], cmd_count[CmdStop], cmd_count[CmdBusErr],
             cmd_count[CmdSpareLo] + cmd_count[CmdSpareHi], checked);
    if (errors == 0) begin
      $display("tb_i2c_loaded_three_channel_pwm: done, clean");
    end else begin
      $display("tb_i2c_loaded_three_channel_pwm: done, errors");
    end
    $finish;
  end

endmodule
